FILE: design/cle_pkg.sv
// Package for the console line editor: item and result word types, key codes,
// status codes, ring index helpers and the memory request bundle.
// Depends on nothing; cle_ctrl and console_line_editor import it.
package cle_pkg;

    // Ring geometry. Indices run modulo twice the depth; a slot is an index modulo depth.
    localparam int BUFFER_DEPTH = 128;
    localparam int IDX_MOD      = 2 * BUFFER_DEPTH;
    localparam int IDX_W        = $clog2(IDX_MOD);
    localparam int SLOT_W       = $clog2(BUFFER_DEPTH);
    localparam int CHAR_W       = 8;
    localparam int ERASE_W      = 8;

    // Request kinds.
    localparam logic REQ_KEY  = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // Key codes.
    localparam logic [CHAR_W-1:0] KEY_NUL = 8'h00;
    localparam logic [CHAR_W-1:0] CTL_Z   = 8'h1A;
    localparam logic [CHAR_W-1:0] CTL_P   = 8'h10;
    localparam logic [CHAR_W-1:0] CTL_U   = 8'h15;
    localparam logic [CHAR_W-1:0] CTL_H   = 8'h08;
    localparam logic [CHAR_W-1:0] CTL_D   = 8'h04;
    localparam logic [CHAR_W-1:0] KEY_DEL = 8'h7F;
    localparam logic [CHAR_W-1:0] KEY_CR  = 8'h0D;
    localparam logic [CHAR_W-1:0] KEY_LF  = 8'h0A;

    // Control event codes.
    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_REBOOT = 2'd1;
    localparam logic [1:0] EV_PLIST  = 2'd2;

    // Read status codes.
    localparam logic [2:0] RS_NONE     = 3'd0;
    localparam logic [2:0] RS_BYTE     = 3'd1;
    localparam logic [2:0] RS_LINE_END = 3'd2;
    localparam logic [2:0] RS_EOF      = 3'd3;
    localparam logic [2:0] RS_EOF_HELD = 3'd4;
    localparam logic [2:0] RS_EMPTY    = 3'd5;

    // Input word.
    typedef struct packed {
        logic              req_type;
        logic [CHAR_W-1:0] key_code;
        logic              first_of_call;
    } cle_in_t;

    // Result word.
    typedef struct packed {
        logic               echo_valid;
        logic [CHAR_W-1:0]  echo_char;
        logic [ERASE_W-1:0] erase_count;
        logic               line_committed;
        logic [1:0]         control_event;
        logic [2:0]         read_status;
        logic [CHAR_W-1:0]  read_byte;
    } cle_out_t;

    // Request from the sequencer to the line store.
    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        logic [CHAR_W-1:0] wdata;
        logic [SLOT_W-1:0] raddr;
    } cle_mem_req_t;

    // Advance a ring index by one, wrapping at IDX_MOD.
    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] a);
        return (a == IDX_W'(IDX_MOD - 1)) ? '0 : a + IDX_W'(1);
    endfunction

    // Step a ring index back by one, wrapping at IDX_MOD.
    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] a);
        return (a == '0) ? IDX_W'(IDX_MOD - 1) : a - IDX_W'(1);
    endfunction

    // Storage slot of a ring index.
    function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] a);
        logic [IDX_W-1:0] s;
        s = (a >= IDX_W'(BUFFER_DEPTH)) ? a - IDX_W'(BUFFER_DEPTH) : a;
        return s[SLOT_W-1:0];
    endfunction

endpackage

FILE: design/cle_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module cle_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered read data.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

FILE: design/cle_ctrl.sv
// Sequencer of the console line editor: holds the ring indices, decodes each
// word and reads, modifies and writes the line store. Depends on cle_pkg.
module cle_ctrl
    import cle_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  cle_in_t      item,
    output logic         busy,
    output logic         done,
    output cle_out_t     result,
    output cle_mem_req_t mem,
    input  logic [CHAR_W-1:0] mem_rdata
);

    typedef enum logic [1:0] {
        IDLE,
        EXEC,
        KILL_WAIT,
        RD_WAIT
    } state_t;

    state_t             state_reg, state_next;
    cle_in_t            item_reg, item_next;
    logic [IDX_W-1:0]   read_idx_reg, read_idx_next;
    logic [IDX_W-1:0]   commit_idx_reg, commit_idx_next;
    logic [IDX_W-1:0]   edit_idx_reg, edit_idx_next;
    logic [ERASE_W-1:0] count_reg, count_next;
    logic [ERASE_W-1:0] count_sat;
    cle_out_t           result_reg, result_next;
    logic               done_reg, done_next;

    logic [IDX_W:0]     used_cnt;
    logic [IDX_W-1:0]   edit_dec;
    logic [CHAR_W-1:0]  key_char;

    // Keys held between read and edit index, and the derived helpers.
    assign used_cnt = (edit_idx_reg >= read_idx_reg)
                    ? {1'b0, edit_idx_reg} - {1'b0, read_idx_reg}
                    : {1'b0, edit_idx_reg} + (IDX_W+1)'(IDX_MOD) - {1'b0, read_idx_reg};
    assign edit_dec  = idx_dec(edit_idx_reg);
    assign key_char  = (item_reg.key_code == KEY_CR) ? KEY_LF : item_reg.key_code;
    assign count_sat = (count_reg == '1) ? count_reg : count_reg + ERASE_W'(1);

    // Next-state and datapath logic.
    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        read_idx_next   = read_idx_reg;
        commit_idx_next = commit_idx_reg;
        edit_idx_next   = edit_idx_reg;
        count_next      = count_reg;
        result_next     = result_reg;
        done_next       = 1'b0;
        mem             = '0;

        unique case (state_reg)
            IDLE:
            begin
                if (start)
                begin
                    item_next  = item;
                    state_next = EXEC;
                end
            end

            EXEC:
            begin
                result_next = '0;
                state_next  = IDLE;
                done_next   = 1'b1;
                if (item_reg.req_type == REQ_KEY)
                begin
                    unique case (item_reg.key_code) inside
                        CTL_Z:
                        begin
                            result_next.control_event = EV_REBOOT;
                        end
                        CTL_P:
                        begin
                            result_next.control_event = EV_PLIST;
                        end
                        CTL_U:
                        begin
                            // Kill-line walks back one stored key per cycle.
                            count_next = '0;
                            if (edit_idx_reg != commit_idx_reg)
                            begin
                                mem.raddr  = slot_of(edit_dec);
                                state_next = KILL_WAIT;
                                done_next  = 1'b0;
                            end
                        end
                        CTL_H, KEY_DEL:
                        begin
                            if (edit_idx_reg != commit_idx_reg)
                            begin
                                edit_idx_next           = edit_dec;
                                result_next.erase_count = ERASE_W'(1);
                            end
                        end
                        default:
                        begin
                            // Ordinary key: append, echo and maybe commit.
                            if (item_reg.key_code != KEY_NUL &&
                                used_cnt < (IDX_W+1)'(BUFFER_DEPTH))
                            begin
                                mem.we                 = 1'b1;
                                mem.waddr              = slot_of(edit_idx_reg);
                                mem.wdata              = key_char;
                                edit_idx_next          = idx_inc(edit_idx_reg);
                                result_next.echo_valid = 1'b1;
                                result_next.echo_char  = key_char;
                                if (key_char == KEY_LF || key_char == CTL_D ||
                                    used_cnt == (IDX_W+1)'(BUFFER_DEPTH - 1))
                                begin
                                    commit_idx_next            = idx_inc(edit_idx_reg);
                                    result_next.line_committed = 1'b1;
                                end
                            end
                        end
                    endcase
                end
                else
                begin
                    // Read: fetch the oldest committed byte unless none is there.
                    if (read_idx_reg == commit_idx_reg)
                    begin
                        result_next.read_status = RS_EMPTY;
                    end
                    else
                    begin
                        mem.raddr  = slot_of(read_idx_reg);
                        state_next = RD_WAIT;
                        done_next  = 1'b0;
                    end
                end
            end

            KILL_WAIT:
            begin
                // The key before the edit index is now on the read data.
                if (mem_rdata == KEY_LF)
                begin
                    result_next.erase_count = count_reg;
                    state_next              = IDLE;
                    done_next               = 1'b1;
                end
                else
                begin
                    edit_idx_next = edit_dec;
                    count_next    = count_sat;
                    if (edit_dec == commit_idx_reg)
                    begin
                        result_next.erase_count = count_sat;
                        state_next              = IDLE;
                        done_next               = 1'b1;
                    end
                    else
                    begin
                        mem.raddr = slot_of(idx_dec(edit_dec));
                    end
                end
            end

            RD_WAIT:
            begin
                state_next = IDLE;
                done_next  = 1'b1;
                if (mem_rdata == CTL_D)
                begin
                    // End of file is consumed only as the first byte of a call.
                    if (item_reg.first_of_call)
                    begin
                        read_idx_next           = idx_inc(read_idx_reg);
                        result_next.read_status = RS_EOF;
                    end
                    else
                    begin
                        result_next.read_status = RS_EOF_HELD;
                    end
                end
                else
                begin
                    read_idx_next           = idx_inc(read_idx_reg);
                    result_next.read_status = (mem_rdata == KEY_LF) ? RS_LINE_END : RS_BYTE;
                    result_next.read_byte   = mem_rdata;
                end
            end

            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    // State, indices and registered result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= IDLE;
            read_idx_reg   <= '0;
            commit_idx_reg <= '0;
            edit_idx_reg   <= '0;
            result_reg     <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            read_idx_reg   <= read_idx_next;
            commit_idx_reg <= commit_idx_next;
            edit_idx_reg   <= edit_idx_next;
            result_reg     <= result_next;
            done_reg       <= done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        count_reg  <= count_next;
    end

    assign busy   = (state_reg != IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // A result word follows only from work in progress.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg != IDLE))
        else $error("result strobe without an item in progress");

    // The strobe lasts exactly one cycle.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held longer than one cycle");

    // The ring never holds more keys than it has slots.
    a_ring_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_cnt <= (IDX_W+1)'(BUFFER_DEPTH))
        else $error("ring occupancy above its depth");

    // The store is written only while a key word executes.
    a_write_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        mem.we |-> (state_reg == EXEC && item_reg.req_type == REQ_KEY))
        else $error("line store written outside key execution");

endmodule

FILE: design/console_line_editor.sv
// Console line editor: canonical line editing over a ring of key codes.
// A word is accepted in IDLE and executed in EXEC; a read then passes RD_WAIT, and
// a kill-line with keys to erase KILL_WAIT, before done pulses. No new word is taken
// while busy; kill-line walks one stored key a cycle, until a newline or the commit index,
// through the single read port of the line store. start is taken while done shows.
// Reset clears the three ring indices; the line store is not cleared.
module console_line_editor
    import cle_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  cle_in_t  item,
    output logic     busy,
    output logic     done,
    output cle_out_t result
);

    cle_mem_req_t      mem;
    logic [CHAR_W-1:0] mem_rdata;

    // Sequencer.
    cle_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .mem       (mem),
        .mem_rdata (mem_rdata)
    );

    // Line store.
    cle_ram #(
        .DEPTH (BUFFER_DEPTH),
        .WIDTH (CHAR_W)
    ) u_line_store (
        .clk   (clk),
        .we    (mem.we),
        .waddr (mem.waddr),
        .wdata (mem.wdata),
        .raddr (mem.raddr),
        .rdata (mem_rdata)
    );

endmodule
